// ===== hdl/gbd_pkg.sv =====
package gbd_pkg;

  // Field widths of the coordinate and configuration words.
  localparam int FRAC_W  = 14;
  localparam int MPM_W   = 12;
  localparam int MPD_W   = 18;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 1;

  // Whole degrees and whole minutes after splitting dddmm.
  localparam int DEG_W = 9;
  localparam int MIN_W = 7;

  // Degree difference times metres per degree.
  localparam int PD_W = DEG_W + MPD_W;

  // Per-axis metre distance. This bound holds for every minute scale in range.
  localparam int DIST_W = 28;

  // The quotient bits of the slope ratio (fixed point, one is 1024).
  localparam int ATAN_ONE = 1024;
  localparam int ATAN_Q_W = 11;

  // x / 100 computed as (x * 5243) >> 19. This is exact for x below 43699.
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SHR = 19;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MPM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MPD = 1'd1;
  localparam logic [MPM_W-1:0] MPM_RESET = 12'd1852;
  localparam logic [MPD_W-1:0] MPD_RESET = 18'd111120;

  // Direction codes.
  localparam logic [2:0] OCT_N  = 3'd0;
  localparam logic [2:0] OCT_NE = 3'd1;
  localparam logic [2:0] OCT_E  = 3'd2;
  localparam logic [2:0] OCT_SE = 3'd3;
  localparam logic [2:0] OCT_S  = 3'd4;
  localparam logic [2:0] OCT_SW = 3'd5;
  localparam logic [2:0] OCT_W  = 3'd6;
  localparam logic [2:0] OCT_NW = 3'd7;

  // What one axis unit hands on beside its minute product.
  typedef struct packed {
    logic [PD_W-1:0] pd;   // whole degree part in metres
    logic            gt;   // here lies beyond goal on this axis
    logic            lt;   // goal lies beyond here on this axis
  } axis_side_t;

  // What travels beside the slope division.
  typedef struct packed {
    logic [2:0]  oct;
    logic [15:0] range;
    logic        swap;     // height exceeds width, so the angle is mirrored
    logic        same;
  } ang_side_t;

endpackage

// ===== hdl/gbd_div.sv =====
module gbd_div #(
  parameter int NUM_W  = 39,
  parameter int DEN_W  = 28,
  parameter int QUO_W  = 11,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // Restoring division, one quotient bit per stage. The numerator must be
  // below the denominator shifted left by QUO_W.
  localparam int X_W = DEN_W + QUO_W;

  logic [X_W-1:0]    x_r    [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic              v_r    [QUO_W];
  logic [X_W-1:0]    x_init;

  function automatic logic [X_W-1:0] div_step(input logic [X_W-1:0] x,
                                               input logic [DEN_W-1:0] d);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] df;
    logic           q;
    sh = x[X_W-1:QUO_W-1];
    q  = (sh >= {1'b0, d});
    df = q ? (sh - {1'b0, d}) : sh;
    return {df[DEN_W-1:0], x[QUO_W-2:0], q};
  endfunction

  // Upper part starts as the partial remainder, lower part as the dividend bits.
  assign x_init = {DEN_W'(in_num >> QUO_W), in_num[QUO_W-1:0]};

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [X_W-1:0]    x_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (k == 0) begin : g_first
      assign x_in = x_init;
      assign d_in = in_den;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign d_in = den_r[k-1];
      assign s_in = side_r[k-1];
      assign v_in = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= div_step(x_in, d_in);
        den_r[k]  <= d_in;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_quo   = x_r[QUO_W-1][QUO_W-1:0];
  assign out_side  = side_r[QUO_W-1];

endmodule

// ===== hdl/gbd_axis.sv =====
module gbd_axis #(
  parameter int WHOLE_W      = 15,
  parameter int MINUTE_SCALE = 10000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [WHOLE_W-1:0]            here_whole,
  input  logic [gbd_pkg::FRAC_W-1:0]    here_frac,
  input  logic [WHOLE_W-1:0]            goal_whole,
  input  logic [gbd_pkg::FRAC_W-1:0]    goal_frac,
  input  logic [gbd_pkg::MPM_W-1:0]     mpm,
  input  logic [gbd_pkg::MPD_W-1:0]     mpd,
  output logic                          out_valid,
  output logic [gbd_pkg::DIST_W-1:0]    out_min_m,
  output gbd_pkg::axis_side_t           out_side
);

  import gbd_pkg::*;

  // Minutes-and-fraction value, wide enough to take a borrowed degree.
  localparam int SW   = $clog2(159*MINUTE_SCALE+16384);
  localparam int PS_W = SW + MPM_W;
  localparam int HP_W = WHOLE_W + 13;

  // Division by the minute scale as a multiplication by ceil(2^RSH / scale).
  // With RSH = PS_W + clog2(scale) the quotient is exact below 2^PS_W.
  localparam int RK   = $clog2(MINUTE_SCALE);
  localparam int RSH  = PS_W + RK;
  localparam int RM_W = PS_W + 1;
  localparam int LO_W = PS_W / 2;
  localparam int HI_W = PS_W - LO_W;
  localparam int PL_W = LO_W + RM_W;
  localparam int PH_W = HI_W + RM_W;
  localparam int PR_W = PS_W + RM_W;
  localparam logic [RM_W-1:0] RECIP =
    RM_W'(((64'd1 << RSH) + 64'(MINUTE_SCALE) - 64'd1) / 64'(MINUTE_SCALE));

  // Stage 1: split dddmm into degrees and minutes, compare the positions.
  logic [DEG_W-1:0]  s1_d1_r, s1_d2_r;
  logic [MIN_W-1:0]  s1_m1_r, s1_m2_r;
  logic [FRAC_W-1:0] s1_f1_r, s1_f2_r;
  logic              s1_gt_r, s1_lt_r, s1_v_r;
  logic [DEG_W-1:0]  d1, d2;
  logic [MIN_W-1:0]  m1, m2;

  function automatic logic [DEG_W-1:0] deg_of(input logic [WHOLE_W-1:0] w);
    logic [HP_W-1:0] hp;
    hp = HP_W'(w) * HP_W'(DIV100_MUL);
    return DEG_W'(hp >> DIV100_SHR);
  endfunction

  assign d1 = deg_of(here_whole);
  assign d2 = deg_of(goal_whole);
  assign m1 = MIN_W'(here_whole - WHOLE_W'(WHOLE_W'(d1) * WHOLE_W'(100)));
  assign m2 = MIN_W'(goal_whole - WHOLE_W'(WHOLE_W'(d2) * WHOLE_W'(100)));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1_r <= d1;
      s1_d2_r <= d2;
      s1_m1_r <= m1;
      s1_m2_r <= m2;
      s1_f1_r <= here_frac;
      s1_f2_r <= goal_frac;
      s1_gt_r <= (here_whole > goal_whole) ||
                 ((here_whole == goal_whole) && (here_frac > goal_frac));
      s1_lt_r <= (goal_whole > here_whole) ||
                 ((goal_whole == here_whole) && (goal_frac > here_frac));
    end
  end

  // Stage 2: scale minutes to fraction units and order the degrees.
  logic [SW-1:0]    s2_s1_r, s2_s2_r;
  logic [DEG_W-1:0] s2_dd_r;
  logic             s2_deq_r, s2_dgt_r, s2_gt_r, s2_lt_r, s2_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s1_r  <= SW'(s1_m1_r) * SW'(MINUTE_SCALE) + SW'(s1_f1_r);
      s2_s2_r  <= SW'(s1_m2_r) * SW'(MINUTE_SCALE) + SW'(s1_f2_r);
      s2_deq_r <= (s1_d1_r == s1_d2_r);
      s2_dgt_r <= (s1_d1_r > s1_d2_r);
      s2_dd_r  <= (s1_d1_r > s1_d2_r) ? (s1_d1_r - s1_d2_r) : (s1_d2_r - s1_d1_r);
      s2_gt_r  <= s1_gt_r;
      s2_lt_r  <= s1_lt_r;
    end
  end

  // Stage 3: borrow a degree where the minute difference would not be positive.
  logic [SW-1:0]    s3_sd_r;
  logic [DEG_W-1:0] s3_dd_r;
  logic             s3_gt_r, s3_lt_r, s3_v_r;
  logic [SW-1:0]    hi, lo, hi_b, sd;
  logic [DEG_W-1:0] dd;

  always_comb begin
    hi   = s2_dgt_r ? s2_s1_r : s2_s2_r;
    lo   = s2_dgt_r ? s2_s2_r : s2_s1_r;
    hi_b = hi;
    dd   = s2_dd_r;
    if (s2_deq_r) begin
      dd = '0;
      sd = (s2_s1_r >= s2_s2_r) ? (s2_s1_r - s2_s2_r) : (s2_s2_r - s2_s1_r);
    end else begin
      if (!(hi > lo)) begin
        dd   = s2_dd_r - DEG_W'(1);
        hi_b = hi + SW'(60*MINUTE_SCALE);
      end
      sd = (hi_b >= lo) ? (hi_b - lo) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sd_r <= sd;
      s3_dd_r <= dd;
      s3_gt_r <= s2_gt_r;
      s3_lt_r <= s2_lt_r;
    end
  end

  // Stage 4: scale both parts to metres.
  logic [PS_W-1:0] s4_ps_r;
  axis_side_t      s4_side_r;
  logic            s4_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ps_r      <= PS_W'(s3_sd_r) * PS_W'(mpm);
      s4_side_r.pd <= PD_W'(s3_dd_r) * PD_W'(mpd);
      s4_side_r.gt <= s3_gt_r;
      s4_side_r.lt <= s3_lt_r;
    end
  end

  // Stage 5: partial products of the minute product and the reciprocal.
  logic [PL_W-1:0] s5_plo_r;
  logic [PH_W-1:0] s5_phi_r;
  axis_side_t      s5_side_r;
  logic            s5_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_plo_r  <= PL_W'(s4_ps_r[LO_W-1:0]) * PL_W'(RECIP);
      s5_phi_r  <= PH_W'(s4_ps_r[PS_W-1:LO_W]) * PH_W'(RECIP);
      s5_side_r <= s4_side_r;
    end
  end

  // Stage 6: combine the partial products and keep the quotient.
  logic [DIST_W-1:0] s6_q_r;
  axis_side_t        s6_side_r;
  logic              s6_v_r;
  logic [PR_W-1:0]   psum;

  assign psum = (PR_W'(s5_phi_r) << LO_W) + PR_W'(s5_plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q_r    <= DIST_W'(psum >> RSH);
      s6_side_r <= s5_side_r;
    end
  end

  // Valid bits follow the data through all six stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  assign out_valid = s6_v_r;
  assign out_min_m = s6_q_r;
  assign out_side  = s6_side_r;

endmodule

// ===== hdl/gps_bearing_distance_unit.sv =====
// Flat-earth bearing and distance between a current and a destination
// position given in dddmm form with fractional minutes.
// Input channel: in_valid/in_ready carry both positions. Result channel:
// out_valid/out_ready carry octant, range, axis angle, same-point flag and
// compass bearing. Configuration: cfg_we writes cfg_wdata into register
// cfg_index (0 metres per minute, 1 metres per degree); write it only while
// the pipeline is empty.
// Throughput: one transfer per cycle on each side unless the receiver stalls.
// Pipeline: each axis takes six stages (split, minute scaling, borrow,
// metre products and a two-stage reciprocal multiplication for the
// division by the minute scale), then three stages form the distances
// and the range, the slope divider takes 11 stages at one quotient bit
// per stage, and four stages finish the angle and the bearing.
// Reset clears every valid bit and loads the register reset values.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops. No item is lost or repeated.
module gps_bearing_distance_unit #(
  parameter int MINUTE_SCALE = 10000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [14:0]                   in_here_lon_whole,
  input  logic [13:0]                   in_here_lon_frac,
  input  logic [13:0]                   in_here_lat_whole,
  input  logic [13:0]                   in_here_lat_frac,
  input  logic [14:0]                   in_goal_lon_whole,
  input  logic [13:0]                   in_goal_lon_frac,
  input  logic [13:0]                   in_goal_lat_whole,
  input  logic [13:0]                   in_goal_lat_frac,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_heading_octant,
  output logic [15:0]                   out_range_meters,
  output logic [6:0]                    out_axis_angle_deg,
  output logic                          out_same_point,
  output logic [8:0]                    out_compass_bearing_deg,
  input  logic                          cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0]     cfg_wdata
);

  import gbd_pkg::*;

  localparam int ANS_W  = $bits(ang_side_t);
  localparam int NUM_W  = DIST_W + ATAN_Q_W;
  localparam int RS_W   = DIST_W + 3;

  logic en;

  // The whole pipeline advances unless a result waits on a stalled receiver.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers.
  logic [MPM_W-1:0] mpm_r;
  logic [MPD_W-1:0] mpd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpm_r <= MPM_RESET;
      mpd_r <= MPD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MPM: mpm_r <= cfg_wdata[MPM_W-1:0];
        CFG_MPD: mpd_r <= cfg_wdata[MPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-axis front end: degree split, borrow and metre distances.
  logic              lon_v, lat_v;
  logic [DIST_W-1:0] q_lon, q_lat;
  axis_side_t        lon_s, lat_s;

  gbd_axis #(.WHOLE_W(15), .MINUTE_SCALE(MINUTE_SCALE)) u_axis_lon (
    .clk, .rst_n, .en,
    .in_valid   (in_valid && in_ready),
    .here_whole (in_here_lon_whole),
    .here_frac  (in_here_lon_frac),
    .goal_whole (in_goal_lon_whole),
    .goal_frac  (in_goal_lon_frac),
    .mpm        (mpm_r),
    .mpd        (mpd_r),
    .out_valid  (lon_v),
    .out_min_m  (q_lon),
    .out_side   (lon_s)
  );

  gbd_axis #(.WHOLE_W(14), .MINUTE_SCALE(MINUTE_SCALE)) u_axis_lat (
    .clk, .rst_n, .en,
    .in_valid   (in_valid && in_ready),
    .here_whole (in_here_lat_whole),
    .here_frac  (in_here_lat_frac),
    .goal_whole (in_goal_lat_whole),
    .goal_frac  (in_goal_lat_frac),
    .mpm        (mpm_r),
    .mpd        (mpd_r),
    .out_valid  (lat_v),
    .out_min_m  (q_lat),
    .out_side   (lat_s)
  );

  // R1: axis distances and the direction code.
  logic [DIST_W-1:0] r1_w_r, r1_h_r;
  logic [2:0]        r1_oct_r, oct;
  logic              r1_v_r;

  always_comb begin
    if (lon_s.lt) begin
      oct = lat_s.gt ? OCT_SE : (lat_s.lt ? OCT_NE : OCT_E);
    end else if (lon_s.gt) begin
      oct = lat_s.gt ? OCT_SW : (lat_s.lt ? OCT_NW : OCT_W);
    end else begin
      oct = lat_s.gt ? OCT_S : OCT_N;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_w_r   <= DIST_W'(lon_s.pd) + q_lon;
      r1_h_r   <= DIST_W'(lat_s.pd) + q_lat;
      r1_oct_r <= oct;
    end
  end

  // R2: order the two distances.
  logic [DIST_W-1:0] r2_mx_r, r2_mn_r;
  logic [2:0]        r2_oct_r;
  logic              r2_swap_r, r2_same_r, r2_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_swap_r <= (r1_h_r > r1_w_r);
      r2_mx_r   <= (r1_h_r > r1_w_r) ? r1_h_r : r1_w_r;
      r2_mn_r   <= (r1_h_r > r1_w_r) ? r1_w_r : r1_h_r;
      r2_same_r <= (r1_w_r == '0) && (r1_h_r == '0);
      r2_oct_r  <= r1_oct_r;
    end
  end

  // R3: octagonal range and the rounded slope dividend.
  logic [NUM_W-1:0]  r3_num_r;
  logic [DIST_W-1:0] r3_den_r;
  ang_side_t         r3_side_r;
  logic              r3_v_r;
  logic [RS_W-1:0]   rsum;

  assign rsum = RS_W'(r2_mx_r) + ((RS_W'(r2_mn_r) * RS_W'(3)) >> 3);

  always_ff @(posedge clk) begin
    if (en) begin
      r3_num_r        <= (NUM_W'(r2_mn_r) << 10) + NUM_W'(r2_mx_r >> 1);
      r3_den_r        <= r2_mx_r;
      r3_side_r.oct   <= r2_oct_r;
      r3_side_r.range <= (rsum > RS_W'(65535)) ? 16'hFFFF : rsum[15:0];
      r3_side_r.swap  <= r2_swap_r;
      r3_side_r.same  <= r2_same_r;
    end
  end

  // Slope ratio, scaled so that one is 1024.
  logic                da_v;
  logic [ATAN_Q_W-1:0] z;
  logic [ANS_W-1:0]    da_side;
  ang_side_t           a_s;

  gbd_div #(.NUM_W(NUM_W), .DEN_W(DIST_W), .QUO_W(ATAN_Q_W), .SIDE_W(ANS_W)) u_div_ang (
    .clk, .rst_n, .en,
    .in_valid  (r3_v_r),
    .in_num    (r3_num_r),
    .in_den    (r3_den_r),
    .in_side   (r3_side_r),
    .out_valid (da_v),
    .out_quo   (z),
    .out_side  (da_side)
  );

  assign a_s = da_side;

  // T1: clamp the ratio and form the curve factor.
  logic [ATAN_Q_W-1:0] t1_z_r, zc;
  logic [12:0]         t1_curve_r;
  ang_side_t           t1_side_r;
  logic                t1_v_r;
  logic [20:0]         cprod;

  assign zc    = (z > ATAN_Q_W'(ATAN_ONE)) ? ATAN_Q_W'(ATAN_ONE) : z;
  assign cprod = 21'(1564) * 21'(ATAN_Q_W'(ATAN_ONE) - zc);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_z_r     <= zc;
      t1_curve_r <= 13'(4500) + 13'(cprod >> 10);
      t1_side_r  <= a_s;
    end
  end

  // T2: angle in hundredths of a degree.
  logic [13:0] t2_a100_r;
  ang_side_t   t2_side_r;
  logic        t2_v_r;
  logic [23:0] aprod;

  assign aprod = 24'(t1_z_r) * 24'(t1_curve_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t2_a100_r <= 14'(aprod >> 10);
      t2_side_r <= t1_side_r;
    end
  end

  // T3: round to whole degrees and mirror when the height dominates.
  logic [6:0]  t3_ang_r, ang_raw;
  ang_side_t   t3_side_r;
  logic        t3_v_r;
  logic [26:0] rprod;

  assign rprod   = 27'(t2_a100_r + 14'd50) * 27'(DIV100_MUL);
  assign ang_raw = 7'(rprod >> DIV100_SHR);

  always_ff @(posedge clk) begin
    if (en) begin
      if (t2_side_r.same) begin
        t3_ang_r <= '0;
      end else if (t2_side_r.swap) begin
        t3_ang_r <= 7'd90 - ang_raw;
      end else begin
        t3_ang_r <= ang_raw;
      end
      t3_side_r <= t2_side_r;
    end
  end

  // T4: compass bearing; these registers drive the result channel.
  logic [2:0]  t4_oct_r;
  logic [15:0] t4_range_r;
  logic [6:0]  t4_ang_r;
  logic        t4_same_r, t4_v_r;
  logic [8:0]  t4_bear_r, bear;

  always_comb begin
    case (t3_side_r.oct)
      OCT_NE:  bear = 9'd90 - 9'(t3_ang_r);
      OCT_E:   bear = 9'd90;
      OCT_SE:  bear = 9'd90 + 9'(t3_ang_r);
      OCT_S:   bear = 9'd180;
      OCT_SW:  bear = 9'd270 - 9'(t3_ang_r);
      OCT_W:   bear = 9'd270;
      OCT_NW:  bear = 9'd270 + 9'(t3_ang_r);
      default: bear = 9'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_oct_r   <= t3_side_r.oct;
      t4_range_r <= t3_side_r.range;
      t4_ang_r   <= t3_ang_r;
      t4_same_r  <= t3_side_r.same;
      t4_bear_r  <= bear;
    end
  end

  // Valid bits of the stages around the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= lon_v;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
      t1_v_r <= da_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
    end
  end

  assign out_valid               = t4_v_r;
  assign out_heading_octant      = t4_oct_r;
  assign out_range_meters        = t4_range_r;
  assign out_axis_angle_deg      = t4_ang_r;
  assign out_same_point          = t4_same_r;
  assign out_compass_bearing_deg = t4_bear_r;

  // A coincident pair reports a zero angle.
  a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_same_point |-> out_axis_angle_deg == 7'd0)
    else $error("same point with nonzero angle");

  // The angle never exceeds a right angle.
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_axis_angle_deg <= 7'd90)
    else $error("axis angle above 90");

  // Both axis lanes carry the same items in lockstep.
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    lon_v == lat_v)
    else $error("axis lanes out of step");

  // East and west directions give fixed bearings.
  a_axis_bear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_heading_octant == OCT_E || out_heading_octant == OCT_W) |->
    out_compass_bearing_deg == 9'd90 || out_compass_bearing_deg == 9'd270)
    else $error("axis bearing mismatch");

endmodule

// ===== test/gps_bearing_distance_unit_tb.sv =====
module gps_bearing_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbd_pkg::*;

  localparam int unsigned SCALE = 10000;
  localparam int DRAIN_CYCLES = 80;

  // One position pair as it crosses the input channel.
  typedef struct packed {
    logic [14:0] here_lon_w;
    logic [13:0] here_lon_f;
    logic [13:0] here_lat_w;
    logic [13:0] here_lat_f;
    logic [14:0] goal_lon_w;
    logic [13:0] goal_lon_f;
    logic [13:0] goal_lat_w;
    logic [13:0] goal_lat_f;
  } fix_pair_t;

  localparam int PAIR_W = $bits(fix_pair_t);

  // One bearing and distance result.
  typedef struct packed {
    logic [2:0]  octant;
    logic [15:0] range_m;
    logic [6:0]  angle;
    logic        same;
    logic [8:0]  bearing;
  } bearing_t;

  typedef struct {
    fix_pair_t pos;
    bit        typed;
    bearing_t  res;
  } nav_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fix_pair_t in_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_heading_octant;
  logic [15:0] out_range_meters;
  logic [6:0] out_axis_angle_deg;
  logic out_same_point;
  logic [8:0] out_compass_bearing_deg;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the scale registers.
  longint unsigned mpm_shadow = 1852;
  longint unsigned mpd_shadow = 111120;

  bearing_t pending_bearings[$];
  nav_row_t nav_rows[$];
  int fails = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  gps_bearing_distance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_here_lon_whole(in_pos.here_lon_w), .in_here_lon_frac(in_pos.here_lon_f),
    .in_here_lat_whole(in_pos.here_lat_w), .in_here_lat_frac(in_pos.here_lat_f),
    .in_goal_lon_whole(in_pos.goal_lon_w), .in_goal_lon_frac(in_pos.goal_lon_f),
    .in_goal_lat_whole(in_pos.goal_lat_w), .in_goal_lat_frac(in_pos.goal_lat_f),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_heading_octant(out_heading_octant), .out_range_meters(out_range_meters),
    .out_axis_angle_deg(out_axis_angle_deg), .out_same_point(out_same_point),
    .out_compass_bearing_deg(out_compass_bearing_deg),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Lexicographic compare of (whole, frac) pairs.
  function automatic bit coord_beyond(longint unsigned aw, longint unsigned af,
                                      longint unsigned bw, longint unsigned bf);
    return (aw > bw) || (aw == bw && af > bf);
  endfunction

  // Metre distance along one axis, with the degree borrow.
  function automatic longint unsigned axis_metres(longint unsigned w1, longint unsigned f1,
                                                  longint unsigned w2, longint unsigned f2);
    longint unsigned d1, d2, s1, s2, dd, hi, lo, sd;
    d1 = w1 / 100;
    d2 = w2 / 100;
    s1 = (w1 % 100) * SCALE + f1;
    s2 = (w2 % 100) * SCALE + f2;
    if (d1 == d2) begin
      sd = (s1 >= s2) ? s1 - s2 : s2 - s1;
      return sd * mpm_shadow / SCALE;
    end
    if (d1 > d2) begin
      dd = d1 - d2; hi = s1; lo = s2;
    end else begin
      dd = d2 - d1; hi = s2; lo = s1;
    end
    if (!(hi > lo)) begin
      dd = dd - 1;
      hi = hi + 60 * SCALE;
    end
    sd = (hi >= lo) ? hi - lo : 0;
    return dd * mpd_shadow + sd * mpm_shadow / SCALE;
  endfunction

  // Polynomial arctangent of a slope in 1/1024 units, in whole degrees.
  function automatic longint unsigned slope_degrees(longint unsigned z);
    longint unsigned curve;
    if (z > ATAN_ONE) z = ATAN_ONE;
    curve = 4500 + (1564 * (ATAN_ONE - z)) / ATAN_ONE;
    return ((z * curve) / ATAN_ONE + 50) / 100;
  endfunction

  function automatic bearing_t predict_bearing(fix_pair_t p);
    bearing_t r;
    bit west, east, south, north;
    longint unsigned w, h, mx, mn, rng, ang;
    west  = coord_beyond(p.here_lon_w, p.here_lon_f, p.goal_lon_w, p.goal_lon_f);
    east  = coord_beyond(p.goal_lon_w, p.goal_lon_f, p.here_lon_w, p.here_lon_f);
    south = coord_beyond(p.here_lat_w, p.here_lat_f, p.goal_lat_w, p.goal_lat_f);
    north = coord_beyond(p.goal_lat_w, p.goal_lat_f, p.here_lat_w, p.here_lat_f);
    if (east) r.octant = south ? OCT_SE : (north ? OCT_NE : OCT_E);
    else if (west) r.octant = south ? OCT_SW : (north ? OCT_NW : OCT_W);
    else r.octant = south ? OCT_S : OCT_N;
    w = axis_metres(p.here_lon_w, p.here_lon_f, p.goal_lon_w, p.goal_lon_f);
    h = axis_metres(p.here_lat_w, p.here_lat_f, p.goal_lat_w, p.goal_lat_f);
    if (w >= h) begin
      mx = w; mn = h;
    end else begin
      mx = h; mn = w;
    end
    rng = mx + ((mn * 3) >> 3);
    r.range_m = (rng > 65535) ? 16'hFFFF : rng[15:0];
    ang = 0;
    r.same = 1'b0;
    if (w == 0) begin
      if (h == 0) r.same = 1'b1;
      else ang = 90;
    end else if (h <= w) begin
      ang = slope_degrees(((h << 10) + (w >> 1)) / w);
    end else begin
      ang = 90 - slope_degrees(((w << 10) + (h >> 1)) / h);
    end
    r.angle = ang[6:0];
    case (r.octant)
      OCT_NE: r.bearing = 9'(90 - ang);
      OCT_E:  r.bearing = 9'd90;
      OCT_SE: r.bearing = 9'(90 + ang);
      OCT_S:  r.bearing = 9'd180;
      OCT_SW: r.bearing = 9'(270 - ang);
      OCT_W:  r.bearing = 9'd270;
      OCT_NW: r.bearing = 9'(270 + ang);
      default: r.bearing = 9'd0;
    endcase
    return r;
  endfunction

  function automatic void add_row(fix_pair_t p, bit typed, bearing_t r);
    nav_row_t row;
    row.pos = p;
    row.typed = typed;
    row.res = r;
    nav_rows.push_back(row);
  endfunction

  function automatic fix_pair_t pair_of(int hlw, int hlf, int haw, int haf,
                                        int glw, int glf, int gaw, int gaf);
    fix_pair_t p;
    p = '{15'(hlw), 14'(hlf), 14'(haw), 14'(haf), 15'(glw), 14'(glf), 14'(gaw), 14'(gaf)};
    return p;
  endfunction

  // Random position pair: mostly nearby points so the range stays below saturation.
  function automatic fix_pair_t random_pair();
    fix_pair_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      p = PAIR_W'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      p.here_lon_w = 15'($urandom_range(18059));
      p.here_lat_w = 14'($urandom_range(9059));
      p.here_lon_f = 14'($urandom_range(9999));
      p.here_lat_f = 14'($urandom_range(9999));
      p.goal_lon_f = 14'($urandom_range(9999));
      p.goal_lat_f = 14'($urandom_range(9999));
      if (pick < 35) begin
        p.goal_lon_w = 15'($urandom_range(18059));
        p.goal_lat_w = 14'($urandom_range(9059));
      end else begin
        p.goal_lon_w = 15'(int'(p.here_lon_w) + $urandom_range(4) - 2);
        p.goal_lat_w = 14'(int'(p.here_lat_w) + $urandom_range(4) - 2);
        if ($urandom_range(4) == 0) p.goal_lat_w = p.here_lat_w;
        if ($urandom_range(4) == 0) p.goal_lon_w = p.here_lon_w;
        if ($urandom_range(9) == 0) p.goal_lon_f = p.here_lon_f;
        if ($urandom_range(9) == 0) p.goal_lat_f = p.here_lat_f;
      end
    end
    return p;
  endfunction

  // Offer one pair and hold it until the transfer happens.
  task automatic send_pair(fix_pair_t p, bit typed, bearing_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos <= p;
    do @(posedge clk); while (!in_ready);
    pending_bearings.push_back(typed ? r : predict_bearing(p));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bearings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scales(int unsigned mpm, int unsigned mpd, bit dirty_high);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MPM;
    cfg_wdata <= dirty_high ? (CFG_W'(mpm) | 18'h3F000) : CFG_W'(mpm);
    @(posedge clk);
    cfg_index <= CFG_MPD;
    cfg_wdata <= CFG_W'(mpd);
    @(posedge clk);
    cfg_we <= 1'b0;
    mpm_shadow = mpm & 12'hFFF;
    mpd_shadow = mpd & 18'h3FFFF;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    bearing_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bearings.size() == 0) begin
        fails++;
        $display("%0t unexpected transfer, expected none actual octant %0d range %0d",
                 $realtime, out_heading_octant, out_range_meters);
      end else begin
        want = pending_bearings.pop_front();
        check_field("octant", want.octant, out_heading_octant);
        check_field("range", want.range_m, out_range_meters);
        check_field("angle", want.angle, out_axis_angle_deg);
        check_field("same_point", want.same, out_same_point);
        check_field("bearing", want.bearing, out_compass_bearing_deg);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned mpm_set[7];
    int unsigned mpd_set[7];
    bearing_t none;
    none = '0;
    mpm_set = '{1852, 4095, 1, 4095, 1, 0, 0};
    mpd_set = '{111120, 262143, 1, 1, 262143, 0, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: fixed answers where they are obvious at reset scales.
    add_row(pair_of(0, 0, 0, 0, 0, 0, 0, 0), 1, '{OCT_N, 16'd0, 7'd0, 1'b1, 9'd0});
    add_row(pair_of(500, 0, 300, 0, 600, 0, 300, 0), 1, '{OCT_E, 16'hFFFF, 7'd0, 1'b0, 9'd90});
    add_row(pair_of(600, 0, 300, 0, 500, 0, 300, 0), 1, '{OCT_W, 16'hFFFF, 7'd0, 1'b0, 9'd270});
    add_row(pair_of(500, 0, 300, 0, 500, 0, 400, 0), 1, '{OCT_N, 16'hFFFF, 7'd90, 1'b0, 9'd0});
    add_row(pair_of(500, 0, 400, 0, 500, 0, 300, 0), 1, '{OCT_S, 16'hFFFF, 7'd90, 1'b0, 9'd180});
    add_row(pair_of(18059, 9999, 9059, 9999, 0, 0, 0, 0), 0, none);
    add_row(pair_of(0, 0, 0, 0, 18059, 9999, 9059, 9999), 0, none);
    add_row(pair_of(32767, 16383, 16383, 16383, 0, 0, 0, 0), 0, none);
    add_row(pair_of(0, 16383, 16383, 0, 32767, 0, 0, 16383), 0, none);
    add_row(pair_of(10, 0, 10, 0, 10, 5000, 10, 5000), 0, none);
    add_row(pair_of(10, 100, 10, 200, 10, 50, 10, 150), 0, none);
    add_row(pair_of(10, 300, 10, 0, 10, 0, 10, 2), 0, none);
    add_row(pair_of(10, 0, 10, 0, 11, 0, 12, 9), 0, none);
    add_row(pair_of(1230, 42, 2000, 0, 1330, 42, 2000, 0), 0, none);
    add_row(pair_of(1259, 9999, 4500, 0, 1300, 0, 4500, 0), 0, none);
    add_row(pair_of(100, 0, 700, 0, 99, 0, 700, 0), 0, none);
    add_row(pair_of(250, 7, 700, 0, 250, 7, 650, 3), 0, none);
    add_row(pair_of(7000, 1, 8000, 5, 6959, 9999, 8001, 5), 0, none);
    foreach (nav_rows[i]) send_pair(nav_rows[i].pos, nav_rows[i].typed, nav_rows[i].res);

    // Random phases over several scale settings and idling patterns.
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      if (ph >= 5) begin
        mpm_set[ph] = $urandom_range(4095, 1);
        mpd_set[ph] = $urandom_range(262143, 1);
      end
      if (ph > 0) write_scales(mpm_set[ph], mpd_set[ph], ph == 3);
      if (ph < 2) begin
        tx_idle_pct = 32; rx_idle_pct = 65;
      end else if (ph < 4) begin
        tx_idle_pct = 65; rx_idle_pct = 32;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      for (int n = 0; n < 270; n++) begin
        // Hold off mid-phase until the pipeline has emptied.
        if (n == 135 && ph == 1) begin
          in_valid <= 1'b0;
          while (pending_bearings.size() != 0) @(posedge clk);
        end
        send_pair(random_pair(), 0, none);
      end
    end

    wait_drained();
    if (fails == 0 && pending_bearings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
